// ===== design/ping_pong_byte_log_buffer_assert.svh =====
// ============================================================================
// Assertion macros for the ping-pong byte log buffer
// Concurrent assertion helpers that compile away when SYNTHESIS is defined.
// ============================================================================
`ifndef PING_PONG_BYTE_LOG_BUFFER_ASSERT_SVH
`define PING_PONG_BYTE_LOG_BUFFER_ASSERT_SVH
`ifndef SYNTHESIS
`define PPBLB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PPBLB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PPBLB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define PPBLB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/ppblb_pkg.sv =====
// ============================================================================
// Ping-pong byte log buffer package
// Sizes, request and state codes shared by the buffer and its testbench.
// ============================================================================
`default_nettype none

package ppblb_pkg;

    localparam int LOG_BYTES = 2048;
    localparam int LANE_W    = 2;
    localparam int LANES     = 1 << LANE_W;
    localparam int ADDR_W    = $clog2(LOG_BYTES);
    localparam int WORD_W    = ADDR_W - LANE_W;
    localparam int LOG_WORDS = LOG_BYTES / LANES;
    localparam int MID_BYTES = LOG_BYTES / 2;
    localparam int POS_W     = 11;
    localparam int BYTE_W    = 8;
    localparam int DATA_W    = BYTE_W * LANES;

    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_READ   = 2'd1,
        REQ_DRAIN  = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_FREE1 = 3'd0,
        ST_FREE2 = 3'd1,
        ST_WR1   = 3'd2,
        ST_WR2   = 3'd3,
        ST_OWR1  = 3'd4,
        ST_OWR2  = 3'd5
    } t_half_state;

    localparam logic [1:0] READY_NONE   = 2'd0;
    localparam logic [1:0] READY_FIRST  = 2'd1;
    localparam logic [1:0] READY_SECOND = 2'd2;

endpackage

`default_nettype wire

// ===== design/ppblb_ram.sv =====
// ============================================================================
// Log word memory
// Single-port-write, single-port-read word memory with byte enables and a
// registered read port.
// ============================================================================
`default_nettype none

module ppblb_ram #(
    parameter int ADDR_W = 9,
    parameter int LANES  = 4
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_we,
    input  wire logic [ADDR_W-1:0]      i_wr_addr,
    input  wire logic [LANES-1:0]       i_be,
    input  wire logic [LANES*8-1:0]     i_wdata,
    input  wire logic                   i_re,
    input  wire logic [ADDR_W-1:0]      i_rd_addr,
    output logic      [LANES*8-1:0]     o_rdata
);

    logic [LANES*8-1:0] r_mem [(1 << ADDR_W)];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            for (int k = 0; k < LANES; k++) begin
                if (i_be[k]) begin
                    r_mem[i_wr_addr][8*k +: 8] <= i_wdata[8*k +: 8];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/ping_pong_byte_log_buffer.sv =====
// ============================================================================
// Ping-pong byte log buffer
// Circular byte log in a word memory with a ping-pong half tracker.
// ============================================================================
// The block takes one transaction per clock cycle while o_stall is low and
// returns one result for each: the registered read of the log memory comes
// first, then the load of the output register. Appends write their byte with
// a byte-lane enable at acceptance and update the write count and half state
// in the same cycle, so a later read always sees the byte. When the output
// register is held by the consumer, one more transaction is still taken into
// the memory-read stage before i_stall propagates to o_stall.
`default_nettype none

module ping_pong_byte_log_buffer (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic [1:0]              i_req_type,
    input  wire logic [7:0]              i_data_byte,
    input  wire logic [10:0]             i_read_address,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic      [7:0]              o_read_byte,
    output logic      [1:0]              o_ready_half,
    output logic      [2:0]              o_fill_state,
    output logic      [10:0]             o_write_position
);

    import ppblb_pkg::*;

    logic                  w_accept;
    logic                  w_load_out;
    t_req                  w_req;
    logic [ADDR_W-1:0]     w_rd_addr;
    logic [ADDR_W:0]       w_count_inc;
    logic [ADDR_W-1:0]     w_count_app;
    logic [DATA_W-1:0]     w_rdata;
    logic [LANES-1:0]      w_be;
    logic [1:0]            w_ready;

    logic [ADDR_W-1:0]     r_count;
    logic [ADDR_W-1:0]     n_count;
    t_half_state           r_half;
    t_half_state           n_half;

    logic                  r_s1_valid;
    t_req                  r_s1_req;
    logic [LANE_W-1:0]     r_s1_lane;
    logic [1:0]            r_s1_ready;
    t_half_state           r_s1_half;
    logic [ADDR_W-1:0]     r_s1_count;

    logic                  r_out_valid;
    logic [BYTE_W-1:0]     r_out_byte;
    logic [1:0]            r_out_ready;
    t_half_state           r_out_half;
    logic [ADDR_W-1:0]     r_out_count;

    assign w_req      = t_req'(i_req_type);
    assign w_load_out = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall    = r_s1_valid && !w_load_out;
    assign w_accept   = i_valid && !o_stall;
    assign w_rd_addr  = ADDR_W'(i_read_address);

    assign w_count_inc = {1'b0, r_count} + (ADDR_W+1)'(1);
    assign w_count_app = (w_count_inc == (ADDR_W+1)'(LOG_BYTES)) ? '0
                                                                  : w_count_inc[ADDR_W-1:0];
    assign w_be = LANES'(1) << r_count[LANE_W-1:0];

    ppblb_ram #(
        .ADDR_W (WORD_W),
        .LANES  (LANES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_accept && (w_req == REQ_APPEND)),
        .i_wr_addr (r_count[ADDR_W-1:LANE_W]),
        .i_be      (w_be),
        .i_wdata   ({LANES{i_data_byte}}),
        .i_re      (w_accept && (w_req == REQ_READ)),
        .i_rd_addr (w_rd_addr[ADDR_W-1:LANE_W]),
        .o_rdata   (w_rdata)
    );

    always_comb begin
        n_count = r_count;
        if (w_accept && (w_req == REQ_APPEND)) begin
            n_count = w_count_app;
        end
    end

    always_comb begin
        n_half = r_half;
        if (w_accept) begin
            case (w_req)
                REQ_APPEND: begin
                    unique case (r_half)
                        ST_FREE1: if (w_count_app > ADDR_W'(MID_BYTES)) n_half = ST_WR1;
                        ST_FREE2: if (w_count_app < ADDR_W'(MID_BYTES)) n_half = ST_WR2;
                        ST_WR1:   if (w_count_app < ADDR_W'(MID_BYTES)) n_half = ST_OWR2;
                        ST_WR2:   if (w_count_app > ADDR_W'(MID_BYTES)) n_half = ST_OWR1;
                        default:  n_half = r_half;
                    endcase
                end
                REQ_DRAIN: begin
                    unique case (r_half)
                        ST_WR1, ST_OWR1: n_half = ST_FREE2;
                        ST_WR2, ST_OWR2: n_half = ST_FREE1;
                        default:         n_half = r_half;
                    endcase
                end
                default: n_half = r_half;
            endcase
        end
    end

    always_comb begin
        w_ready = READY_NONE;
        if (w_req == REQ_DRAIN) begin
            unique case (r_half)
                ST_WR1, ST_OWR1: w_ready = READY_FIRST;
                ST_WR2, ST_OWR2: w_ready = READY_SECOND;
                default:         w_ready = READY_NONE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_half      <= ST_FREE1;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_half  <= n_half;
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_load_out) begin
                r_s1_valid <= 1'b0;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_req   <= w_req;
            r_s1_lane  <= w_rd_addr[LANE_W-1:0];
            r_s1_ready <= w_ready;
            r_s1_half  <= n_half;
            r_s1_count <= n_count;
        end
        if (w_load_out) begin
            r_out_byte  <= (r_s1_req == REQ_READ) ? w_rdata[BYTE_W*r_s1_lane +: BYTE_W]
                                                  : '0;
            r_out_ready <= r_s1_ready;
            r_out_half  <= r_s1_half;
            r_out_count <= r_s1_count;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_read_byte      = r_out_byte;
    assign o_ready_half     = r_out_ready;
    assign o_fill_state     = 3'(r_out_half);
    assign o_write_position = POS_W'(r_out_count);

`include "ping_pong_byte_log_buffer_assert.svh"

    `PPBLB_ASSERT_NEXT(a_count_step, i_clk, i_rst_n,
        w_accept && (w_req == REQ_APPEND),
        (r_count == $past(r_count) + ADDR_W'(1)) || (r_count == '0),
        "Append did not advance the write count by one.")
    `PPBLB_ASSERT_NEXT(a_count_hold, i_clk, i_rst_n,
        !(w_accept && (w_req == REQ_APPEND)), $stable(r_count),
        "Write count changed without an append.")
    `PPBLB_ASSERT_NEXT(a_drain_frees, i_clk, i_rst_n,
        w_accept && (w_req == REQ_DRAIN) && (w_ready != READY_NONE),
        (r_half == ST_FREE1) || (r_half == ST_FREE2),
        "Drain of a ready half did not free it.")
    `PPBLB_ASSERT_NOW(a_result_excl, i_clk, i_rst_n,
        r_out_valid && (r_out_ready != READY_NONE), r_out_byte == '0,
        "Drain result carries a nonzero read byte.")
    `PPBLB_ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n,
        r_s1_valid && !w_load_out, r_s1_valid && $stable(r_s1_count),
        "Memory-read stage lost or changed a held transaction.")

endmodule

`default_nettype wire

// ===== tb/ping_pong_byte_log_buffer_tb.sv =====
// ============================================================================
// Ping-pong byte log buffer testbench
// Drives append, read, drain and unused requests through the valid/stall
// input channel and checks every result on the output channel against an
// in-order prediction of the byte log, the write count and the half state.
// The random traffic mixes bursts of appends with reads of already written
// bytes, with phases where drains are rare so that the halves fill up.
// ============================================================================
`timescale 1ns / 100ps

module ping_pong_byte_log_buffer_tb;

    import ppblb_pkg::*;

    localparam int unsigned RANDOM_ITEMS   = 1400;
    localparam int unsigned DRAIN_WINDOW   = 1500;
    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned SETTLE_CYCLES  = 10;
    localparam int unsigned PRINT_LIMIT    = 50;

    class log_result_board;
        typedef struct {
            logic [7:0]  read_byte;
            logic [1:0]  ready_half;
            logic [2:0]  fill_state;
            logic [10:0] write_position;
        } t_log_result;

        t_log_result pending_results[$];
        logic [DATA_W-1:0] log_words [LOG_WORDS];
        logic [10:0] write_count;
        t_half_state half_state;
        int unsigned bytes_filled;
        int unsigned wraps;
        bit [5:0] states_seen;
        int unsigned mismatches;

        function new();
            write_count  = '0;
            half_state   = ST_FREE1;
            bytes_filled = 0;
            wraps        = 0;
            states_seen  = 6'b000001;
            mismatches   = 0;
        endfunction

        function bit fully_covered();
            return (states_seen == 6'b111111) && (wraps >= 2);
        endfunction

        task report_mismatch(input string msg);
            if (mismatches < PRINT_LIMIT) begin
                $display("%0t: mismatch: %s", $realtime, msg);
            end
            mismatches++;
        endtask

        function void note_request(input t_req req, input logic [7:0] data,
                                   input logic [10:0] addr);
            t_log_result exp;
            int unsigned byte_addr;
            exp.read_byte  = '0;
            exp.ready_half = READY_NONE;
            case (req)
                REQ_APPEND: begin
                    log_words[write_count / LANES][BYTE_W*(write_count % LANES) +: BYTE_W]
                        = data;
                    if (write_count == LOG_BYTES - 1) begin
                        write_count = '0;
                        wraps++;
                    end else begin
                        write_count = write_count + 1'b1;
                    end
                    if (bytes_filled < LOG_BYTES) begin
                        bytes_filled++;
                    end
                    case (half_state)
                        ST_FREE1: if (write_count > MID_BYTES) half_state = ST_WR1;
                        ST_FREE2: if (write_count < MID_BYTES) half_state = ST_WR2;
                        ST_WR1:   if (write_count < MID_BYTES) half_state = ST_OWR2;
                        ST_WR2:   if (write_count > MID_BYTES) half_state = ST_OWR1;
                        default: ;
                    endcase
                end
                REQ_READ: begin
                    byte_addr = addr % LOG_BYTES;
                    exp.read_byte =
                        log_words[byte_addr / LANES][BYTE_W*(byte_addr % LANES) +: BYTE_W];
                end
                REQ_DRAIN: begin
                    case (half_state)
                        ST_WR1, ST_OWR1: begin
                            exp.ready_half = READY_FIRST;
                            half_state     = ST_FREE2;
                        end
                        ST_WR2, ST_OWR2: begin
                            exp.ready_half = READY_SECOND;
                            half_state     = ST_FREE1;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
            states_seen[half_state] = 1'b1;
            exp.fill_state     = half_state;
            exp.write_position = write_count;
            pending_results.push_back(exp);
        endfunction

        task check_result(input logic [7:0] read_byte, input logic [1:0] ready_half,
                          input logic [2:0] fill_state, input logic [10:0] write_position);
            t_log_result exp;
            if (pending_results.size() == 0) begin
                report_mismatch("result with no transaction pending");
            end else begin
                exp = pending_results.pop_front();
                if (read_byte !== exp.read_byte || ready_half !== exp.ready_half ||
                    fill_state !== exp.fill_state ||
                    write_position !== exp.write_position) begin
                    report_mismatch($sformatf(
                        "byte %h/%h ready %0d/%0d state %0d/%0d position %0d/%0d",
                        read_byte, exp.read_byte, ready_half, exp.ready_half,
                        fill_state, exp.fill_state, write_position, exp.write_position));
                end
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_req_type;
    logic [7:0]  i_data_byte;
    logic [10:0] i_read_address;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_read_byte;
    logic [1:0]  o_ready_half;
    logic [2:0]  o_fill_state;
    logic [10:0] o_write_position;

    log_result_board board = new();
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned drain_pct;
    int unsigned drain_window_left;
    int unsigned idle_cycles;

    ping_pong_byte_log_buffer u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_req_type       (i_req_type),
        .i_data_byte      (i_data_byte),
        .i_read_address   (i_read_address),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_read_byte      (o_read_byte),
        .o_ready_half     (o_ready_half),
        .o_fill_state     (o_fill_state),
        .o_write_position (o_write_position)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            board.check_result(o_read_byte, o_ready_half, o_fill_state, o_write_position);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(input t_req req, input logic [7:0] data,
                             input logic [10:0] addr);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_req_type     <= req;
        i_data_byte    <= data;
        i_read_address <= addr;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_request(req, data, addr);
        @(negedge i_clk);
    endtask

    task automatic wait_all_results();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (board.pending_results.size() != 0);
    endtask

    task automatic run_random_phase(input int unsigned min_items,
                                    input int unsigned max_items);
        int unsigned n;
        int unsigned pick;
        int          span;
        int          back;
        t_req        req;
        logic [10:0] addr;
        n = 0;
        while (n < min_items || (n < max_items && !board.fully_covered())) begin
            if (drain_window_left == 0) begin
                drain_window_left = DRAIN_WINDOW;
                case ($urandom_range(0, 3))
                    0, 1:    drain_pct = 0;
                    2:       drain_pct = 1;
                    default: drain_pct = 4;
                endcase
            end
            drain_window_left--;
            pick = $urandom_range(0, 99);
            if (pick < drain_pct) begin
                req = REQ_DRAIN;
            end else if (pick < 80 || board.bytes_filled == 0) begin
                req = REQ_APPEND;
            end else if (pick < 97) begin
                req = REQ_READ;
            end else begin
                req = REQ_NONE;
            end
            if (req == REQ_READ) begin
                if ($urandom_range(0, 1) == 1) begin
                    span = (board.bytes_filled < 16) ? board.bytes_filled : 16;
                    back = int'(board.write_count) - 1 - int'($urandom_range(0, span - 1));
                    if (back < 0) begin
                        back += LOG_BYTES;
                    end
                    addr = back[10:0];
                end else begin
                    addr = 11'($urandom_range(0, board.bytes_filled - 1));
                end
            end else begin
                addr = 11'($urandom_range(0, LOG_BYTES - 1));
            end
            send_item(req, 8'($urandom_range(0, 255)), addr);
            n++;
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_valid           = 1'b0;
        i_stall           = 1'b0;
        i_req_type        = REQ_NONE;
        i_data_byte       = '0;
        i_read_address    = '0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        drain_pct         = 0;
        drain_window_left = 0;
        idle_cycles       = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct  = 28;
        recv_stall_pct = 50;
        send_item(REQ_DRAIN,  8'h00, 11'h7FF);
        send_item(REQ_NONE,   8'hFF, 11'h7FF);
        send_item(REQ_APPEND, 8'h00, 11'h7FF);
        send_item(REQ_APPEND, 8'hFF, 11'h000);
        send_item(REQ_APPEND, 8'h55, 11'h555);
        send_item(REQ_APPEND, 8'hAA, 11'h2AA);
        send_item(REQ_APPEND, 8'h01, 11'h7FF);
        send_item(REQ_APPEND, 8'h80, 11'h400);
        send_item(REQ_READ,   8'hFF, 11'h000);
        send_item(REQ_READ,   8'h00, 11'h001);
        send_item(REQ_READ,   8'hFF, 11'h002);
        send_item(REQ_READ,   8'h00, 11'h003);
        send_item(REQ_READ,   8'hFF, 11'h004);
        send_item(REQ_READ,   8'h00, 11'h005);
        send_item(REQ_DRAIN,  8'hFF, 11'h000);
        send_item(REQ_APPEND, 8'h7F, 11'h000);
        send_item(REQ_READ,   8'h00, 11'h006);
        send_item(REQ_NONE,   8'h00, 11'h000);
        send_item(REQ_READ,   8'hFF, 11'h000);
        wait_all_results();

        run_random_phase(RANDOM_ITEMS / 6, RANDOM_ITEMS / 6);
        wait_all_results();
        run_random_phase(RANDOM_ITEMS / 6, RANDOM_ITEMS / 6);
        wait_all_results();

        send_idle_pct  = 50;
        recv_stall_pct = 28;
        run_random_phase(RANDOM_ITEMS / 3, RANDOM_ITEMS / 3);
        wait_all_results();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random_phase(RANDOM_ITEMS / 3, RANDOM_ITEMS / 3);
        wait_all_results();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (board.pending_results.size() != 0) begin
            board.report_mismatch($sformatf("%0d results never arrived",
                                            board.pending_results.size()));
        end
        if (board.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/ppblb_pkg.sv
design/ppblb_ram.sv
design/ping_pong_byte_log_buffer.sv
tb/ping_pong_byte_log_buffer_tb.sv
